FILE: rtl/frac_red_pkg.sv
// Package for the fraction arithmetic block: operation codes, field widths
// and the packed request and result types used on the top-level ports.
// No dependencies.
package frac_red_pkg;

  // Operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Fixed field widths
  localparam int IN_FIELD_W = 16;
  localparam int NUM_OUT_W  = 33;
  localparam int DEN_OUT_W  = 32;

  // One request: operation and two fractions
  typedef struct packed {
    logic [1:0]                    cmd;
    logic signed [IN_FIELD_W-1:0]  num_a;
    logic signed [IN_FIELD_W-1:0]  den_a;
    logic signed [IN_FIELD_W-1:0]  num_b;
    logic signed [IN_FIELD_W-1:0]  den_b;
  } frac_in_t;

  // One result: reduced fraction and zero-denominator flag
  typedef struct packed {
    logic signed [NUM_OUT_W-1:0] num_out;
    logic signed [DEN_OUT_W-1:0] den_out;
    logic                        zero_den;
  } frac_out_t;

endpackage

FILE: rtl/fraction_arith_reduce.sv
// Fraction arithmetic with partial reduction by 2, 3 and 5.
// Depends on frac_red_pkg (request/result types, operation codes).
//
// Channel   Ports                        Handshake
// request   start, busy, in_req          taken when start && !busy
// result    out_valid, out_res           one-cycle strobe, no back-pressure
//
// Steps per request: no products for add/sub with equal denominators, two
// for multiply and divide, three for add/sub with cross products (one shared
// signed multiplier), then one test step per reduction round. A round that
// removes a factor 2 takes only the test step; a factor 3 or 5 adds M shift-add
// steps of exact division by the constant, with M = clog2(2*EW+1)-1
// (M = 5 at the default width). The final test step issues the result.
// Synchronous active-low reset returns the sequencer to idle.
// busy is high from the cycle after a request is taken until the result
// strobe; a new request may be taken in the strobe cycle.
module fraction_arith_reduce
  import frac_red_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  frac_in_t  in_req,
  output logic      out_valid,
  output frac_out_t out_res
);

  // Operand width after extension: above the field width the fields are
  // taken as non-negative, so one extra bit holds them.
  localparam int SB  = (OPERAND_WIDTH < IN_FIELD_W) ? OPERAND_WIDTH : IN_FIELD_W;
  localparam int EW  = (OPERAND_WIDTH <= IN_FIELD_W) ? OPERAND_WIDTH : IN_FIELD_W + 1;
  localparam int PW  = 2 * EW;
  localparam int VW  = 2 * EW + 1;
  localparam int M   = $clog2(VW) - 1;
  localparam int STW = $clog2(M);
  localparam int SHW = $clog2(VW);
  localparam int NNIB = (VW + 3) / 4;
  localparam int SIGN_CORR = 15 - (1 << (VW % 4));

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_TEST = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             cmd_r, cmd_nxt;
  logic signed [EW-1:0]   na_r, na_nxt, da_r, da_nxt, nb_r, nb_nxt, db_r, db_nxt;
  logic signed [VW-1:0]   n_r, n_nxt, d_r, d_nxt;
  logic                   k3_r, k3_nxt;
  logic [STW-1:0]         step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  frac_out_t              out_res_r, out_res_nxt;

  logic signed [EW-1:0]   na_e, da_e, nb_e, db_e;
  logic signed [EW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   prod;
  logic [3:0]             n_res, d_res;

  // Sign extension from the operand width (zero extension above the field)
  function automatic logic signed [EW-1:0] ext_op(input logic [IN_FIELD_W-1:0] x);
    if (OPERAND_WIDTH <= IN_FIELD_W) begin
      return EW'(signed'(x[SB-1:0]));
    end else begin
      return EW'(x[SB-1:0]);
    end
  endfunction

  // Residue mod 15 of a signed value: nibble sum (16 = 1 mod 15) plus the
  // weight of the sign bit, folded twice. 0 and 15 both mean zero.
  function automatic logic [3:0] res15(input logic [VW-1:0] x);
    logic [4*NNIB-1:0] padded;
    logic [7:0]        acc;
    logic [4:0]        f1;
    logic [4:0]        f2;
    padded = (4*NNIB)'(x);
    acc = x[VW-1] ? 8'(SIGN_CORR) : 8'd0;
    for (int i = 0; i < NNIB; i++) begin
      acc = acc + 8'(padded[4*i +: 4]);
    end
    f1 = 5'(acc[7:4]) + 5'(acc[3:0]);
    f2 = 5'(f1[3:0]) + 5'(f1[4]);
    return f2[3:0];
  endfunction

  function automatic logic div3(input logic [3:0] r);
    case (r) inside
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: return 1'b1;
      default:                              return 1'b0;
    endcase
  endfunction

  function automatic logic div5(input logic [3:0] r);
    case (r) inside
      4'd0, 4'd5, 4'd10, 4'd15: return 1'b1;
      default:                  return 1'b0;
    endcase
  endfunction

  // One step of exact division by 3 or 5: multiply by the inverse mod 2^VW,
  // built as a product of (1 + 2^(2^(i+1))) terms. Step 0 gives -(1+4) for 3
  // and (1-4) for 5.
  function automatic logic signed [VW-1:0] fstep(input logic signed [VW-1:0] x,
                                                  input logic k3,
                                                  input logic [STW-1:0] i);
    logic signed [VW-1:0] q;
    logic [SHW-1:0]       sh;
    sh = SHW'(2) << i;
    if (i == '0) begin
      q = k3 ? -(x + (x <<< 2)) : (x - (x <<< 2));
    end else begin
      q = x + (x << sh);
    end
    return q;
  endfunction

  assign na_e = ext_op(in_req.num_a);
  assign da_e = ext_op(in_req.den_a);
  assign nb_e = ext_op(in_req.num_b);
  assign db_e = ext_op(in_req.den_b);

  // Shared multiplier operand selection
  always_comb begin
    mul_a = da_r;
    mul_b = db_r;
    case (state_r)
      S_MUL0: begin
        mul_a = da_r;
        mul_b = (cmd_r == CMD_DIV) ? nb_r : db_r;
      end
      S_MUL1: begin
        mul_a = na_r;
        mul_b = (cmd_r == CMD_MUL) ? nb_r : db_r;
      end
      S_MUL2: begin
        mul_a = nb_r;
        mul_b = da_r;
      end
      default: begin
        mul_a = da_r;
        mul_b = db_r;
      end
    endcase
  end

  assign prod  = PW'(mul_a) * PW'(mul_b);
  assign n_res = res15(n_r);
  assign d_res = res15(d_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    na_nxt        = na_r;
    da_nxt        = da_r;
    nb_nxt        = nb_r;
    db_nxt        = db_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    k3_nxt        = k3_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_req.cmd;
          na_nxt  = na_e;
          da_nxt  = da_e;
          nb_nxt  = nb_e;
          db_nxt  = db_e;
          // shared denominator: no products needed
          if ((in_req.cmd == CMD_ADD || in_req.cmd == CMD_SUB) && da_e == db_e) begin
            n_nxt = (in_req.cmd == CMD_SUB) ? VW'(na_e) - VW'(nb_e)
                                            : VW'(na_e) + VW'(nb_e);
            d_nxt = VW'(da_e);
            state_nxt = S_TEST;
          end else begin
            state_nxt = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        d_nxt     = VW'(prod);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        n_nxt     = VW'(prod);
        state_nxt = (cmd_r == CMD_MUL || cmd_r == CMD_DIV) ? S_TEST : S_MUL2;
      end
      S_MUL2: begin
        n_nxt     = (cmd_r == CMD_SUB) ? n_r - VW'(prod) : n_r + VW'(prod);
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (d_r == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{num_out: NUM_OUT_W'(n_r), den_out: DEN_OUT_W'(d_r),
                            zero_den: 1'b1};
          state_nxt     = S_IDLE;
        end else if (!n_r[0] && !d_r[0]) begin
          n_nxt = n_r >>> 1;
          d_nxt = d_r >>> 1;
        end else if (div3(n_res) && div3(d_res)) begin
          k3_nxt    = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else if (div5(n_res) && div5(d_res)) begin
          k3_nxt    = 1'b0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = '{num_out: NUM_OUT_W'(n_r), den_out: DEN_OUT_W'(d_r),
                            zero_den: 1'b0};
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        n_nxt    = fstep(n_r, k3_r, step_r);
        d_nxt    = fstep(d_r, k3_r, step_r);
        step_nxt = step_r + STW'(1);
        if (step_r == STW'(M - 1)) begin
          state_nxt = S_TEST;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    na_r      <= na_nxt;
    da_r      <= da_nxt;
    nb_r      <= nb_nxt;
    db_r      <= db_nxt;
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    k3_r      <= k3_nxt;
    step_r    <= step_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.zero_den |-> out_res.den_out == '0)
    else $error("zero-denominator flag with non-zero denominator");

endmodule
